@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of the project.
// Each macro asserts one property on the rising edge of clk; PSS_ASSERT is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge while out of reset
`define PSS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check a property on every rising clock edge, reset included
`define PSS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

@@ rtl/pss_pkg.sv @@
// Package for the pitch scale snapper: widths, register indexes and the
// pitch-class helper. Depends on nothing; used by the top level and its checker.
`default_nettype none

package pss_pkg;

    localparam int NOTE_W  = 7;
    localparam int OUT_W   = 9;
    localparam int CLASS_W = 12;
    localparam int DIST_W  = 4;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // Notes up to 127 plus the offset below fit in eight bits
    localparam int SUM_W = NOTE_W + 1;

    // -69 mod 12: adding this puts A at pitch class 0
    localparam logic [SUM_W-1:0] PITCH_OFFSET = SUM_W'(3);
    localparam logic [SUM_W-1:0] TONES        = SUM_W'(12);

    // Reciprocal of twelve scaled by 2^11, exact for values up to 130
    localparam logic [SUM_W-1:0] RECIP_12    = SUM_W'(171);
    localparam int               RECIP_SHIFT = 11;

    // Register index, taken from paddr bit 2
    localparam logic REG_SCALE  = 1'b0;
    localparam logic REG_PREFER = 1'b1;

    typedef logic [CLASS_W-1:0] class_mask_t;

    // Pitch class of a note, A = 0
    function automatic logic [DIST_W-1:0] pitch_class(input logic [NOTE_W-1:0] note);
        logic [SUM_W-1:0]   v;
        logic [2*SUM_W-1:0] prod;
        logic [SUM_W-1:0]   q;
        logic [SUM_W-1:0]   r;
        v    = SUM_W'(note) + PITCH_OFFSET;
        prod = v * RECIP_12;
        q    = SUM_W'(prod >> RECIP_SHIFT);
        r    = v - SUM_W'(q * TONES);
        return r[DIST_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/pitch_scale_snap_top.sv @@
// Pitch scale snapper: input register, one pass of snapping logic, result register.
// Depends on pss_pkg for widths, register indexes and the pitch-class helper.
//
// Usage
//   Input channel (in_valid/in_ready) carries note_in and snap_up; output
//   channel (out_valid/out_ready) carries note_out, a signed 9-bit note that
//   is not clamped to the MIDI range. A transfer happens where valid and
//   ready are both high.
//   The APB port holds scale_mask at address 0 and prefer_mask at address 4
//   (decoded on paddr bit 2). pready is tied high; write only while idle.
//   A note accepted into the input register moves to the result register and
//   shows on out_valid; a stall at the output holds it in the input register.
//   Throughput: one note per cycle while out_ready holds, set by the two-register
//   pipeline; the snapping logic is a rotate and two 11-bit priority searches.
//   Reset clears both masks (every note then passes unchanged) and empties
//   both pipeline registers.
//   When the receiver stalls the result is held; the input register still
//   takes one more note, then in_ready drops until out_ready returns.
`default_nettype none

module pitch_scale_snap_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Note input channel
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [pss_pkg::NOTE_W-1:0]       note_in,
    input  wire logic                             snap_up,
    // Result channel
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [pss_pkg::OUT_W-1:0]      note_out,
    // Configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pss_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [pss_pkg::DATA_W-1:0]       pwdata,
    output logic [pss_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready
);

    pss_pkg::class_mask_t scale_mask_reg;
    pss_pkg::class_mask_t prefer_mask_reg;

    logic                         s1_valid_reg;
    logic [pss_pkg::NOTE_W-1:0]   s1_note_reg;
    logic                         s1_up_reg;

    logic                                 out_valid_reg;
    logic signed [pss_pkg::OUT_W-1:0]     note_out_reg;
    logic signed [pss_pkg::OUT_W-1:0]     note_out_next;

    logic in_xfer;
    logic out_load;
    logic cfg_write;

    logic [pss_pkg::DIST_W-1:0]   class_c;
    pss_pkg::class_mask_t         allow_c;
    pss_pkg::class_mask_t         pref_c;
    pss_pkg::class_mask_t         arot_c;
    pss_pkg::class_mask_t         prot_c;
    logic [2*pss_pkg::CLASS_W-1:0] adbl_c;
    logic [2*pss_pkg::CLASS_W-1:0] pdbl_c;
    logic [pss_pkg::DIST_W-1:0]   dl_c;
    logic [pss_pkg::DIST_W-1:0]   dh_c;
    logic [pss_pkg::DIST_W-1:0]   lo_idx_c;
    logic signed [pss_pkg::OUT_W-1:0] lo_c;
    logic signed [pss_pkg::OUT_W-1:0] hi_c;

    // Configuration port: always ready, write on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_mask_reg  <= '0;
            prefer_mask_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                pss_pkg::REG_SCALE:  scale_mask_reg  <= pwdata[pss_pkg::CLASS_W-1:0];
                pss_pkg::REG_PREFER: prefer_mask_reg <= pwdata[pss_pkg::CLASS_W-1:0];
                default:             scale_mask_reg  <= scale_mask_reg;
            endcase
        end
    end

    // Read back the addressed mask
    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            pss_pkg::REG_SCALE:  prdata[pss_pkg::CLASS_W-1:0] = scale_mask_reg;
            pss_pkg::REG_PREFER: prdata[pss_pkg::CLASS_W-1:0] = prefer_mask_reg;
            default:             prdata = '0;
        endcase
    end

    // Pipeline flow: load the result register when it is empty or drained
    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || out_load;
    assign in_xfer  = in_valid && in_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_note_reg <= note_in;
            s1_up_reg   <= snap_up;
        end
    end

    // Effective masks: an empty scale allows and prefers every class
    always_comb
    begin
        if (scale_mask_reg == '0)
        begin
            allow_c = '1;
            pref_c  = '1;
        end
        else
        begin
            allow_c = scale_mask_reg;
            pref_c  = prefer_mask_reg & scale_mask_reg;
        end
    end

    // Rotate both masks so the note's own class sits at bit 0
    assign class_c = pss_pkg::pitch_class(s1_note_reg);
    assign adbl_c  = {allow_c, allow_c} >> class_c;
    assign pdbl_c  = {pref_c, pref_c} >> class_c;
    assign arot_c  = adbl_c[pss_pkg::CLASS_W-1:0];
    assign prot_c  = pdbl_c[pss_pkg::CLASS_W-1:0];

    // Search for the nearest allowed class below and above; the lowest distance wins
    always_comb
    begin
        dl_c = pss_pkg::DIST_W'(pss_pkg::CLASS_W);
        dh_c = pss_pkg::DIST_W'(pss_pkg::CLASS_W);
        for (int d = pss_pkg::CLASS_W - 1; d >= 1; d--)
        begin
            if (arot_c[pss_pkg::CLASS_W - d])
            begin
                dl_c = pss_pkg::DIST_W'(d);
            end
            if (arot_c[d])
            begin
                dh_c = pss_pkg::DIST_W'(d);
            end
        end
    end

    assign lo_idx_c = pss_pkg::DIST_W'(pss_pkg::CLASS_W) - dl_c;
    assign lo_c     = $signed(pss_pkg::OUT_W'(s1_note_reg)) - $signed(pss_pkg::OUT_W'(dl_c));
    assign hi_c     = $signed(pss_pkg::OUT_W'(s1_note_reg)) + $signed(pss_pkg::OUT_W'(dh_c));

    // Keep an allowed note, else pick the closer note; break ties on preference, the lower note first, then on snap_up
    always_comb
    begin
        if (arot_c[0])
        begin
            note_out_next = $signed(pss_pkg::OUT_W'(s1_note_reg));
        end
        else if (dh_c < dl_c)
        begin
            note_out_next = hi_c;
        end
        else if (dh_c > dl_c)
        begin
            note_out_next = lo_c;
        end
        else if (prot_c[lo_idx_c])
        begin
            note_out_next = lo_c;
        end
        else if (prot_c[dh_c])
        begin
            note_out_next = hi_c;
        end
        else
        begin
            note_out_next = s1_up_reg ? hi_c : lo_c;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            note_out_reg <= note_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign note_out  = note_out_reg;

endmodule

`default_nettype wire

@@ rtl/pss_checker.sv @@
// Port-level checker for the pitch scale snapper, bound to the top level.
// Depends on pss_pkg for widths and on assert_macros.svh for the assertion macros.
`default_nettype none
`include "assert_macros.svh"

module pss_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [pss_pkg::OUT_W-1:0]     note_out,
    input wire logic [pss_pkg::DATA_W-1:0]    prdata,
    input wire logic                          pready
);

    logic                             out_stall;
    logic                             in_xfer;
    logic signed [pss_pkg::OUT_W-1:0] note_s;

    assign out_stall = out_valid && !out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign note_s    = $signed(note_out);

    // A held result keeps its value until the transfer
    `PSS_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(note_out))

    // Snapped notes stay within eleven semitones of the MIDI range
    `PSS_ASSERT(a_out_range, out_valid |-> (note_s >= -9'sd11) && (note_s <= 9'sd138))

    // A stalled, full pipeline refuses new notes
    `PSS_ASSERT(a_full_stall, out_stall && $past(in_xfer && out_stall) |-> !in_ready)

    // The configuration port never waits and reads back only mask bits
    `PSS_ASSERT_ALWAYS(a_apb_ready, pready && (prdata[pss_pkg::DATA_W-1:pss_pkg::CLASS_W] == '0))

endmodule

bind pitch_scale_snap_top pss_checker u_pss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .note_out  (note_out),
    .prdata    (prdata),
    .pready    (pready)
);

`default_nettype wire
